FILE: rtl/levy_regression_row_builder_core_defines.svh
// Assertion macros shared by the checker of the row builder core.
`ifndef LEVY_REGRESSION_ROW_BUILDER_CORE_DEFINES_SVH
`define LEVY_REGRESSION_ROW_BUILDER_CORE_DEFINES_SVH

// Check a consequent in the same cycle as its antecedent.
`define LRB_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define LRB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/lrb_pkg.sv
// Shared types, constants and rounding functions of the row builder.
package lrb_pkg;

   localparam int DEFAULT_MAX_NUM_ORDER = 16;
   localparam int DEFAULT_MAX_DEN_ORDER = 16;
   localparam int DEFAULT_CORDIC_STEPS  = 24;

   localparam int OPND_W      = 34;
   localparam int PROD_W      = 68;
   localparam int ACC_W       = 70;
   localparam int ORDER_W     = 5;
   localparam int COL_W       = 6;
   localparam int CSR_INDEX_W = 2;
   localparam int DATA_W      = 32;

   localparam logic [29:0]              INV_TWO_PI_Q32  = 30'd683565276;
   localparam logic signed [OPND_W-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;
   localparam logic signed [OPND_W-1:0] ONE_Q30         = 34'sd1073741824;

   localparam logic [ORDER_W-1:0] RESET_NUM_ORDER     = 5'd1;
   localparam logic [ORDER_W-1:0] RESET_DEN_ORDER     = 5'd1;
   localparam logic [DATA_W-1:0]  RESET_SAMPLE_PERIOD = 32'd4294967;

   // arctan(2^-i) in turns, Q0.32, truncated
   localparam logic [31:0] ATAN_TURNS [32] = '{
      32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
      32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C, 32'h000028BE, 32'h0000145F,
      32'h00000A2F, 32'h00000517, 32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051,
      32'h00000028, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001,
      32'h00000000, 32'h00000000
   };

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_NUM_ORDER     = 2'd0,
      CSR_DEN_ORDER     = 2'd1,
      CSR_SAMPLE_PERIOD = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PHASE,
      ST_CORDIC,
      ST_LOAD,
      ST_DENOM,
      ST_WEIGHT,
      ST_EMIT,
      ST_POWER
   } seq_state_type;

   typedef enum logic [1:0] {
      KIND_NUM,
      KIND_DEN,
      KIND_TGT
   } entry_kind_type;

   typedef enum logic [2:0] {
      ACC_HOLD,
      ACC_LOAD,
      ACC_ADD,
      ACC_SUB,
      ACC_NEG,
      ACC_LOAD_HI
   } acc_op_type;

   typedef struct packed {
      acc_op_type               op;
      logic signed [OPND_W-1:0] a;
      logic signed [OPND_W-1:0] b;
   } mac_cmd_type;

   typedef struct packed {
      logic [DATA_W-1:0] value;
      logic              clip;
   } wpart_type;

   // half-up rounding of a Q60 sum back to Q30
   function automatic logic signed [OPND_W-1:0] round30(input logic signed [ACC_W-1:0] acc);
      logic signed [ACC_W-1:0] s;
      s = acc + ACC_W'(536870912);
      s = s >>> 30;
      return s[OPND_W-1:0];
   endfunction

   // magnitude times weight, rounded half away from zero, then saturated
   function automatic wpart_type weight_round(input logic signed [ACC_W-1:0] acc,
                                              input logic neg);
      logic [ACC_W-1:0] s;
      logic [41:0]      r;
      logic signed [42:0] v;
      wpart_type        o;
      s = acc + ACC_W'(8388608);
      r = s[65:24];
      v = neg ? -$signed({1'b0, r}) : $signed({1'b0, r});
      if (v > 43'sd2147483647) begin
         o.value = 32'h7FFF_FFFF;
         o.clip  = 1'b1;
      end else if (v < -43'sd2147483648) begin
         o.value = 32'h8000_0000;
         o.clip  = 1'b1;
      end else begin
         o.value = v[31:0];
         o.clip  = 1'b0;
      end
      return o;
   endfunction

endpackage

FILE: rtl/lrb_channels.sv
// Handshake channel interfaces: sample input, row entry output, register writes.
interface lrb_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] frequency;
   logic signed [31:0] response_real;
   logic signed [31:0] response_imag;
   logic [31:0]        weight;

   modport source (output valid, frequency, response_real, response_imag, weight,
                   input ready);
   modport sink (input valid, frequency, response_real, response_imag, weight,
                 output ready);
endinterface

interface lrb_rsp_if;
   logic               valid;
   logic               ready;
   logic [5:0]         column;
   logic signed [31:0] entry_real;
   logic signed [31:0] entry_imag;
   logic               is_target;
   logic               saturated;
   logic               last;

   modport source (output valid, column, entry_real, entry_imag, is_target, saturated, last,
                   input ready);
   modport sink (input valid, column, entry_real, entry_imag, is_target, saturated, last,
                 output ready);
endinterface

interface lrb_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [31:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/lrb_mac.sv
// Shared signed multiplier with registered product and accumulator.
module lrb_mac (
   input  logic                                clock,
   input  logic                                reset,
   input  lrb_pkg::mac_cmd_type                cmd,
   output logic signed [lrb_pkg::PROD_W-1:0]   prod,
   output logic signed [lrb_pkg::ACC_W-1:0]    acc
);
   import lrb_pkg::*;

   logic signed [PROD_W-1:0] prod_ff;
   acc_op_type               op_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [ACC_W-1:0]  acc_in;
   logic signed [ACC_W-1:0]  prod_ext;

   assign prod_ext = {{(ACC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};

   always_comb begin
      unique case (op_ff)
         ACC_HOLD:    acc_in = acc_ff;
         ACC_LOAD:    acc_in = prod_ext;
         ACC_ADD:     acc_in = acc_ff + prod_ext;
         ACC_SUB:     acc_in = acc_ff - prod_ext;
         ACC_NEG:     acc_in = -prod_ext;
         ACC_LOAD_HI: acc_in = prod_ext <<< 24;
         default:     acc_in = acc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff <= ACC_HOLD;
      end else begin
         op_ff <= cmd.op;
      end
      prod_ff <= cmd.a * cmd.b;
      acc_ff  <= acc_in;
   end

   assign prod = prod_ff;
   assign acc  = acc_ff;

endmodule

FILE: rtl/lrb_cordic.sv
// Iterative rotation-mode CORDIC, one step per cycle.
module lrb_cordic #(
   parameter int CORDIC_STEPS = lrb_pkg::DEFAULT_CORDIC_STEPS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [lrb_pkg::OPND_W-1:0]   angle,
   output logic                                done,
   output logic signed [lrb_pkg::OPND_W-1:0]   x_out,
   output logic signed [lrb_pkg::OPND_W-1:0]   y_out
);
   import lrb_pkg::*;

   localparam int CNT_W = $clog2(CORDIC_STEPS);

   logic                     busy_ff;
   logic                     done_ff;
   logic [CNT_W-1:0]         cnt_ff;
   logic signed [OPND_W-1:0] x_ff, y_ff, z_ff;
   logic signed [OPND_W-1:0] dx, dy, da;
   logic                     final_step;

   assign dx         = y_ff >>> cnt_ff;
   assign dy         = x_ff >>> cnt_ff;
   assign da         = $signed({2'b00, ATAN_TURNS[5'(cnt_ff)]});
   assign final_step = (cnt_ff == CNT_W'(CORDIC_STEPS - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && final_step;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            busy_ff <= !final_step;
            cnt_ff  <= cnt_ff + CNT_W'(1);
         end
      end
      if (start) begin
         x_ff <= CORDIC_GAIN_Q30;
         y_ff <= '0;
         z_ff <= angle;
      end else if (busy_ff) begin
         if (!z_ff[OPND_W-1]) begin
            x_ff <= x_ff - dx;
            y_ff <= y_ff + dy;
            z_ff <= z_ff - da;
         end else begin
            x_ff <= x_ff + dx;
            y_ff <= y_ff - dy;
            z_ff <= z_ff + da;
         end
      end
   end

   assign done  = done_ff;
   assign x_out = x_ff;
   assign y_out = y_ff;

endmodule

FILE: rtl/levy_regression_row_builder_core.sv
// Levy regression row builder: sequencer around a shared multiplier and a CORDIC.
// After an input transaction the phase step and the CORDIC run, then entries leave in order:
//   numerator columns, then denominator columns, then the target. A new sample is taken
//   only in idle, after the target entry; output stalls and the passes through the single
//   34x34 multiplier set the sample rate.
// Reset (synchronous, active high) returns to idle, drops any pending result and reloads.
module levy_regression_row_builder_core #(
   parameter int MAX_NUMERATOR_ORDER   = lrb_pkg::DEFAULT_MAX_NUM_ORDER,
   parameter int MAX_DENOMINATOR_ORDER = lrb_pkg::DEFAULT_MAX_DEN_ORDER,
   parameter int CORDIC_STEPS          = lrb_pkg::DEFAULT_CORDIC_STEPS
) (
   input  logic       clock,
   input  logic       reset,
   lrb_req_if.sink    req_ch,
   lrb_rsp_if.source  rsp_ch,
   lrb_csr_if.sink    csr_ch
);
   import lrb_pkg::*;

   // configuration registers
   logic [ORDER_W-1:0] numer_deg_ff;
   logic [ORDER_W-1:0] denom_deg_ff;
   logic [DATA_W-1:0]  period_ff;

   // sequencer
   seq_state_type  state_ff, state_in;
   logic [2:0]     sub_ff;
   entry_kind_type kind_ff;
   logic [ORDER_W-1:0] idx_ff;
   logic [ORDER_W-1:0] n_ff, d_ff;

   // latched sample
   logic [31:0]        mf_ff;
   logic               pos_ff;
   logic signed [31:0] hr_ff, hi_ff;
   logic [31:0]        w_ff;

   // phase computation
   logic [30:0] m_hi_ff;
   logic [61:0] a_ff;
   logic [31:0] t_ff;
   logic        flip_ff;
   logic [95:0] tsum;
   logic [31:0] phase;
   logic signed [OPND_W-1:0] zs, angle;
   logic        flip_in;

   // complex values, Q4.30
   logic signed [OPND_W-1:0] zr_ff, zi_ff, pr_ff, pi_ff, tr_ff;
   // entry before weighting, Q10.24
   logic signed [OPND_W-1:0] er_ff, ei_ff;
   logic [OPND_W-1:0]        mag_r, mag_i;
   wpart_type                wr_ff, wi_ff;

   // output register
   logic               rsp_valid_ff;
   logic [COL_W-1:0]   rsp_column_ff;
   logic [31:0]        rsp_real_ff, rsp_imag_ff;
   logic               rsp_target_ff, rsp_sat_ff, rsp_last_ff;
   logic               out_free;
   logic [COL_W-1:0]   column;

   // shared units
   mac_cmd_type              mac_cmd;
   logic signed [PROD_W-1:0] mac_prod;
   logic signed [ACC_W-1:0]  mac_acc;
   logic                     cordic_start, cordic_done;
   logic signed [OPND_W-1:0] cx, cy;
   logic                     req_fire;
   logic [ORDER_W-1:0]       n_lim, d_lim;
   logic signed [OPND_W-1:0] hr_ext, hi_ext;

   lrb_mac u_mac (
      .clock (clock),
      .reset (reset),
      .cmd   (mac_cmd),
      .prod  (mac_prod),
      .acc   (mac_acc)
   );

   lrb_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
      .clock (clock),
      .reset (reset),
      .start (cordic_start),
      .angle (angle),
      .done  (cordic_done),
      .x_out (cx),
      .y_out (cy)
   );

   // take a sample only when fully idle; the output register parts the sides
   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;

   // orders above the build limit act as the limit
   assign n_lim = (numer_deg_ff > ORDER_W'(MAX_NUMERATOR_ORDER)) ?
                  ORDER_W'(MAX_NUMERATOR_ORDER) : numer_deg_ff;
   assign d_lim = (denom_deg_ff > ORDER_W'(MAX_DENOMINATOR_ORDER)) ?
                  ORDER_W'(MAX_DENOMINATOR_ORDER) : denom_deg_ff;

   assign hr_ext = {{(OPND_W-32){hr_ff[31]}}, hr_ff};
   assign hi_ext = {{(OPND_W-32){hi_ff[31]}}, hi_ff};
   assign mag_r  = er_ff[OPND_W-1] ? OPND_W'(-er_ff) : OPND_W'(er_ff);
   assign mag_i  = ei_ff[OPND_W-1] ? OPND_W'(-ei_ff) : OPND_W'(ei_ff);

   // phase in turns: bits 79..48 of |w0|*Ts*(1/2pi), negated for positive w0
   assign tsum  = 96'(a_ff) + (96'(mac_prod[60:0]) << 32);
   assign phase = pos_ff ? (32'd0 - t_ff) : t_ff;
   assign zs    = {{(OPND_W-32){phase[31]}}, phase};

   // fold angles past a quarter turn back by half a turn and flip the result
   always_comb begin
      angle   = zs;
      flip_in = 1'b0;
      if (zs > 34'sd1073741824) begin
         angle   = zs - 34'sd2147483648;
         flip_in = 1'b1;
      end else if (zs < -34'sd1073741824) begin
         angle   = zs + 34'sd2147483648;
         flip_in = 1'b1;
      end
   end

   always_comb begin
      unique case (kind_ff)
         KIND_NUM: column = COL_W'(idx_ff);
         KIND_DEN: column = COL_W'(n_ff) + COL_W'(idx_ff);
         default:  column = '0;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_fire) state_in = ST_PHASE;
         ST_PHASE:  if (sub_ff == 3'd4) state_in = ST_CORDIC;
         ST_CORDIC: if (cordic_done) state_in = ST_LOAD;
         ST_LOAD:   state_in = (kind_ff == KIND_DEN) ? ST_DENOM : ST_WEIGHT;
         ST_DENOM:  if (sub_ff == 3'd5) state_in = ST_WEIGHT;
         ST_WEIGHT: if (sub_ff == 3'd5) state_in = ST_EMIT;
         ST_EMIT: begin
            if (out_free) begin
               priority if (kind_ff == KIND_TGT) begin
                  state_in = ST_IDLE;
               end else if (kind_ff == KIND_NUM && idx_ff != n_ff) begin
                  state_in = ST_POWER;
               end else if (kind_ff == KIND_DEN && idx_ff != d_ff) begin
                  state_in = ST_POWER;
               end else begin
                  state_in = ST_LOAD;
               end
            end
         end
         ST_POWER:  if (sub_ff == 3'd5) state_in = ST_LOAD;
         default:   state_in = ST_IDLE;
      endcase
   end

   // multiplier issue and CORDIC start
   always_comb begin
      mac_cmd.op   = ACC_HOLD;
      mac_cmd.a    = '0;
      mac_cmd.b    = '0;
      cordic_start = 1'b0;
      unique case (state_ff)
         ST_PHASE: begin
            unique case (sub_ff)
               3'd0: begin
                  mac_cmd.a = $signed({2'b00, mf_ff});
                  mac_cmd.b = $signed({2'b00, period_ff});
               end
               3'd1: begin
                  mac_cmd.a = $signed({2'b00, mac_prod[31:0]});
                  mac_cmd.b = $signed({4'b0000, INV_TWO_PI_Q32});
               end
               3'd2: begin
                  mac_cmd.a = $signed({3'b000, m_hi_ff});
                  mac_cmd.b = $signed({4'b0000, INV_TWO_PI_Q32});
               end
               3'd4:    cordic_start = 1'b1;
               default: ;
            endcase
         end
         ST_DENOM: begin
            unique case (sub_ff)
               3'd0: begin mac_cmd.op = ACC_LOAD; mac_cmd.a = hi_ext; mac_cmd.b = pi_ff; end
               3'd1: begin mac_cmd.op = ACC_SUB;  mac_cmd.a = hr_ext; mac_cmd.b = pr_ff; end
               3'd2: begin mac_cmd.op = ACC_NEG;  mac_cmd.a = hr_ext; mac_cmd.b = pi_ff; end
               3'd3: begin mac_cmd.op = ACC_SUB;  mac_cmd.a = hi_ext; mac_cmd.b = pr_ff; end
               default: ;
            endcase
         end
         ST_WEIGHT: begin
            mac_cmd.b = $signed({2'b00, w_ff});
            unique case (sub_ff)
               3'd0: begin
                  mac_cmd.op = ACC_LOAD_HI;
                  mac_cmd.a  = $signed(OPND_W'(mag_r[OPND_W-1:24]));
               end
               3'd1: begin
                  mac_cmd.op = ACC_ADD;
                  mac_cmd.a  = $signed(OPND_W'(mag_r[23:0]));
               end
               3'd2: begin
                  mac_cmd.op = ACC_LOAD_HI;
                  mac_cmd.a  = $signed(OPND_W'(mag_i[OPND_W-1:24]));
               end
               3'd3: begin
                  mac_cmd.op = ACC_ADD;
                  mac_cmd.a  = $signed(OPND_W'(mag_i[23:0]));
               end
               default: ;
            endcase
         end
         ST_POWER: begin
            unique case (sub_ff)
               3'd0: begin mac_cmd.op = ACC_LOAD; mac_cmd.a = pr_ff; mac_cmd.b = zr_ff; end
               3'd1: begin mac_cmd.op = ACC_SUB;  mac_cmd.a = pi_ff; mac_cmd.b = zi_ff; end
               3'd2: begin mac_cmd.op = ACC_LOAD; mac_cmd.a = pr_ff; mac_cmd.b = zi_ff; end
               3'd3: begin mac_cmd.op = ACC_ADD;  mac_cmd.a = pi_ff; mac_cmd.b = zr_ff; end
               default: ;
            endcase
         end
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sub_ff       <= '0;
         kind_ff      <= KIND_NUM;
         rsp_valid_ff <= 1'b0;
         numer_deg_ff <= RESET_NUM_ORDER;
         denom_deg_ff <= RESET_DEN_ORDER;
         period_ff    <= RESET_SAMPLE_PERIOD;
      end else begin
         state_ff <= state_in;
         sub_ff   <= (state_in != state_ff) ? 3'd0 : sub_ff + 3'd1;
         if (csr_ch.valid) begin
            unique case (csr_ch.index)
               CSR_NUM_ORDER:     numer_deg_ff <= csr_ch.data[ORDER_W-1:0];
               CSR_DEN_ORDER:     denom_deg_ff <= csr_ch.data[ORDER_W-1:0];
               CSR_SAMPLE_PERIOD: period_ff    <= csr_ch.data;
               default: ;
            endcase
         end
         // advance the entry kind after the last entry of a kind is emitted; numerator after the CORDIC
         if (state_ff == ST_CORDIC && cordic_done) begin
            kind_ff <= KIND_NUM;
         end else if (state_ff == ST_EMIT && out_free) begin
            if (kind_ff == KIND_NUM && idx_ff == n_ff) begin
               kind_ff <= (d_ff == '0) ? KIND_TGT : KIND_DEN;
            end else if (kind_ff == KIND_DEN && idx_ff == d_ff) begin
               kind_ff <= KIND_TGT;
            end
         end
         if (state_ff == ST_EMIT && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               mf_ff  <= req_ch.frequency[31] ? 32'(-req_ch.frequency) : req_ch.frequency;
               pos_ff <= !req_ch.frequency[31] && (req_ch.frequency != 32'sd0);
               hr_ff  <= req_ch.response_real;
               hi_ff  <= req_ch.response_imag;
               w_ff   <= req_ch.weight;
               n_ff   <= n_lim;
               d_ff   <= d_lim;
            end
         end
         ST_PHASE: begin
            if (sub_ff == 3'd1) m_hi_ff <= mac_prod[62:32];
            if (sub_ff == 3'd2) a_ff <= mac_prod[61:0];
            if (sub_ff == 3'd3) t_ff <= tsum[79:48];
            if (sub_ff == 3'd4) flip_ff <= flip_in;
         end
         ST_CORDIC: begin
            if (cordic_done) begin
               zr_ff  <= flip_ff ? -cx : cx;
               zi_ff  <= flip_ff ? -cy : cy;
               pr_ff  <= ONE_Q30;
               pi_ff  <= '0;
               idx_ff <= '0;
            end
         end
         ST_LOAD: begin
            if (kind_ff == KIND_NUM) begin
               er_ff <= (pr_ff + OPND_W'(32)) >>> 6;
               ei_ff <= (pi_ff + OPND_W'(32)) >>> 6;
            end else if (kind_ff == KIND_TGT) begin
               er_ff <= hr_ext;
               ei_ff <= hi_ext;
            end
         end
         ST_DENOM: begin
            if (sub_ff == 3'd3) er_ff <= round30(mac_acc);
            if (sub_ff == 3'd5) ei_ff <= round30(mac_acc);
         end
         ST_WEIGHT: begin
            if (sub_ff == 3'd3) wr_ff <= weight_round(mac_acc, er_ff[OPND_W-1]);
            if (sub_ff == 3'd5) wi_ff <= weight_round(mac_acc, ei_ff[OPND_W-1]);
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_column_ff <= column;
               rsp_real_ff   <= wr_ff.value;
               rsp_imag_ff   <= wi_ff.value;
               rsp_target_ff <= (kind_ff == KIND_TGT);
               rsp_sat_ff    <= wr_ff.clip || wi_ff.clip;
               rsp_last_ff   <= (kind_ff == KIND_TGT);
               if (kind_ff == KIND_NUM && idx_ff == n_ff) begin
                  // restart the powers at zinv for the denominator columns
                  pr_ff  <= zr_ff;
                  pi_ff  <= zi_ff;
                  idx_ff <= ORDER_W'(1);
               end else if (kind_ff != KIND_TGT) begin
                  idx_ff <= idx_ff + ORDER_W'(1);
               end
            end
         end
         ST_POWER: begin
            if (sub_ff == 3'd3) tr_ff <= round30(mac_acc);
            if (sub_ff == 3'd5) begin
               pr_ff <= tr_ff;
               pi_ff <= round30(mac_acc);
            end
         end
         default: ;
      endcase
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.column     = rsp_column_ff;
   assign rsp_ch.entry_real = rsp_real_ff;
   assign rsp_ch.entry_imag = rsp_imag_ff;
   assign rsp_ch.is_target  = rsp_target_ff;
   assign rsp_ch.saturated  = rsp_sat_ff;
   assign rsp_ch.last       = rsp_last_ff;

endmodule

FILE: rtl/lrb_checker.sv
// Port-level assertions for the row builder core, bound to the top level.
`include "levy_regression_row_builder_core_defines.svh"

module lrb_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [5:0] rsp_column,
   input logic       rsp_is_target,
   input logic       rsp_last
);

   `LRB_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "rsp dropped while stalled")
   `LRB_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready, "ready right after accept")
   `LRB_ASSERT_SAME(a_last_is_target, clock, reset, rsp_valid, rsp_last == rsp_is_target, "last and target disagree")
   `LRB_ASSERT_SAME(a_target_column, clock, reset, rsp_valid && rsp_is_target, rsp_column == 6'd0, "target column not zero")

endmodule

bind levy_regression_row_builder_core lrb_checker u_lrb_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_ch.valid),
   .req_ready     (req_ch.ready),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_column    (rsp_ch.column),
   .rsp_is_target (rsp_ch.is_target),
   .rsp_last      (rsp_ch.last)
);
